[rtl/two_body_invariant_mass_unit_defines.svh]
// Shared assertion macros for the invariant mass unit.
`ifndef TWO_BODY_INVARIANT_MASS_UNIT_DEFINES_SVH
`define TWO_BODY_INVARIANT_MASS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TBIM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbim assertion failed");

// Next-cycle implication, checked outside reset.
`define TBIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbim assertion failed");

`endif

[rtl/tbim_pkg.sv]
package tbim_pkg;

  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 35;
  localparam int MSQ_W  = 41;
  localparam int OUT_W  = 29;

  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES          = ROOT_W / SQRT_STEPS_PER_STAGE;

  localparam logic [2:0] HYP_KAON     = 3'd1;
  localparam logic [2:0] HYP_LAMBDA   = 3'd2;
  localparam logic [2:0] HYP_ELECTRON = 3'd3;
  localparam logic [2:0] HYP_PION     = 3'd4;
  localparam logic [2:0] HYP_KAON_ALT = 3'd5;
  localparam logic [2:0] HYP_PROTON   = 3'd6;

  localparam logic [MSQ_W-1:0] KAON_MASS     = 41'd497672;
  localparam logic [MSQ_W-1:0] LAMBDA_MASS   = 41'd1115683;
  localparam logic [MSQ_W-1:0] ELECTRON_MASS = 41'd511;
  localparam logic [MSQ_W-1:0] PION_MASS     = 41'd139570;
  localparam logic [MSQ_W-1:0] PROTON_MASS   = 41'd938272;

  localparam logic [MSQ_W-1:0] KAON_MSQ     = KAON_MASS * KAON_MASS;
  localparam logic [MSQ_W-1:0] LAMBDA_MSQ   = LAMBDA_MASS * LAMBDA_MASS;
  localparam logic [MSQ_W-1:0] ELECTRON_MSQ = ELECTRON_MASS * ELECTRON_MASS;
  localparam logic [MSQ_W-1:0] PION_MSQ     = PION_MASS * PION_MASS;
  localparam logic [MSQ_W-1:0] PROTON_MSQ   = PROTON_MASS * PROTON_MASS;

  typedef struct packed {
    logic [RAD_W-1:0]  x;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_state_t;

  function automatic logic [MSQ_W-1:0] mass_sq(input logic [2:0] code);
    logic [MSQ_W-1:0] r;
    case (code)
      HYP_KAON:     r = KAON_MSQ;
      HYP_KAON_ALT: r = KAON_MSQ;
      HYP_LAMBDA:   r = LAMBDA_MSQ;
      HYP_ELECTRON: r = ELECTRON_MSQ;
      HYP_PION:     r = PION_MSQ;
      HYP_PROTON:   r = PROTON_MSQ;
      default:      r = '0;
    endcase
    return r;
  endfunction

  // one result bit of the restoring square root
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t s);
    sqrt_state_t      n;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    shifted = {s.rem[REM_W-3:0], s.x[RAD_W-1:RAD_W-2]};
    trial   = REM_W'({s.root, 2'b01});
    n.x     = {s.x[RAD_W-3:0], 2'b00};
    if (shifted >= trial) begin
      n.rem  = shifted - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = shifted;
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

[rtl/tbim_sqrt.sv]
module tbim_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [tbim_pkg::RAD_W-1:0] rad_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [tbim_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);
  import tbim_pkg::*;

  sqrt_state_t       st_d    [SQRT_STAGES];
  sqrt_state_t       st_q    [SQRT_STAGES];
  logic [SIDE_W-1:0] side_q  [SQRT_STAGES];
  logic              valid_q [SQRT_STAGES];
  sqrt_state_t       st_in;

  assign st_in = '{x: rad_i, rem: '0, root: '0};

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        st_d[s] = sqrt_step(sqrt_step(st_in));
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        st_q[s]   <= st_d[s];
        side_q[s] <= side_i;
      end
    end else begin : g_rest
      always_comb begin
        st_d[s] = sqrt_step(sqrt_step(st_q[s-1]));
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        st_q[s]   <= st_d[s];
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign valid_o = valid_q[SQRT_STAGES-1];
  assign root_o  = st_q[SQRT_STAGES-1].root;
  assign side_o  = side_q[SQRT_STAGES-1];

`include "two_body_invariant_mass_unit_defines.svh"

  `TBIM_ASSERT_NOW(a_valid_latency, valid_o, $past(valid_i, SQRT_STAGES))

endmodule

[rtl/two_body_invariant_mass_unit.sv]
// channel | dir | handshake        | word
// --------+-----+------------------+----------------------------------------------
// pair in | in  | start_i, busy_o  | two momenta, two hypothesis codes
// result  | out | done_o strobe    | pair_mass_o, pair_energy_o, negative_radicand_o
//
// One pair accepted every cycle; busy_o is always low.
// The pipeline has three product/sum stages, a 16-stage energy square root,
// three stages for the mass radicand and a 16-stage mass square root.
// Each square root stage retires two result bits.
// Reset clears only the valid bits; results cannot be stalled.
module two_body_invariant_mass_unit #(
  parameter int MOMENTUM_BITS = 28
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [MOMENTUM_BITS-1:0]  first_px_i,
  input  logic signed [MOMENTUM_BITS-1:0]  first_py_i,
  input  logic signed [MOMENTUM_BITS-1:0]  first_pz_i,
  input  logic signed [MOMENTUM_BITS-1:0]  second_px_i,
  input  logic signed [MOMENTUM_BITS-1:0]  second_py_i,
  input  logic signed [MOMENTUM_BITS-1:0]  second_pz_i,
  input  logic [2:0]                       first_hypothesis_i,
  input  logic [2:0]                       second_hypothesis_i,
  output logic                             done_o,
  output logic [tbim_pkg::OUT_W-1:0]       pair_mass_o,
  output logic [tbim_pkg::OUT_W-1:0]       pair_energy_o,
  output logic                             negative_radicand_o
);
  import tbim_pkg::*;

  localparam int PROD_W = 2 * MOMENTUM_BITS;

  logic accept;

  logic signed [PROD_W-1:0] m1x, m1y, m1z, m2x, m2y, m2z, mdx, mdy, mdz;

  // stage 1: products
  logic              v1_q;
  logic [RAD_W-1:0]  sq1x_q, sq1y_q, sq1z_q, sq2x_q, sq2y_q, sq2z_q;
  logic signed [RAD_W-1:0] dx_q, dy_q, dz_q;
  logic [MSQ_W-1:0]  m1sq_q, m2sq_q;

  // stage 2: partial sums
  logic              v2_q;
  logic [RAD_W-1:0]  s1ab_q, s1c_q, s2ab_q, s2c_q;
  logic signed [RAD_W-1:0] dab_q, dc_q;
  logic [MSQ_W:0]    msum2_q;

  // stage 3: energy radicands and dot product
  logic              v3_q;
  logic [RAD_W-1:0]  psq1_q, psq2_q;
  logic signed [RAD_W-1:0] dot3_q;
  logic [MSQ_W:0]    msum3_q;

  logic              ve1, ve2;
  logic [ROOT_W-1:0] e1, e2;
  logic [RAD_W-1:0]  dot_side;
  logic [MSQ_W:0]    msum_side;

  // stages 4 to 6: mass radicand
  logic              v4_q, v5_q, v6_q;
  logic [RAD_W-1:0]  prod4_q, pos5_q, rad6_q;
  logic [RAD_W-1:0]  dot4_q, dot5_q;
  logic [MSQ_W:0]    msum4_q;
  logic [OUT_W-1:0]  esum4_q, esum5_q, esum6_q;
  logic              neg6_q;
  logic [ROOT_W:0]   esum_full;
  logic [RAD_W-1:0]  sub5;

  logic              vm;
  logic [ROOT_W-1:0] mroot;
  logic [OUT_W:0]    mside;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign m1x = first_px_i * first_px_i;
  assign m1y = first_py_i * first_py_i;
  assign m1z = first_pz_i * first_pz_i;
  assign m2x = second_px_i * second_px_i;
  assign m2y = second_py_i * second_py_i;
  assign m2z = second_pz_i * second_pz_i;
  assign mdx = first_px_i * second_px_i;
  assign mdy = first_py_i * second_py_i;
  assign mdz = first_pz_i * second_pz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= ve1;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  assign esum_full = {1'b0, e1} + {1'b0, e2};
  assign sub5      = {dot5_q[RAD_W-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    sq1x_q  <= RAD_W'(m1x);
    sq1y_q  <= RAD_W'(m1y);
    sq1z_q  <= RAD_W'(m1z);
    sq2x_q  <= RAD_W'(m2x);
    sq2y_q  <= RAD_W'(m2y);
    sq2z_q  <= RAD_W'(m2z);
    dx_q    <= RAD_W'(mdx);
    dy_q    <= RAD_W'(mdy);
    dz_q    <= RAD_W'(mdz);
    m1sq_q  <= mass_sq(first_hypothesis_i);
    m2sq_q  <= mass_sq(second_hypothesis_i);

    s1ab_q  <= sq1x_q + sq1y_q;
    s1c_q   <= sq1z_q + RAD_W'(m1sq_q);
    s2ab_q  <= sq2x_q + sq2y_q;
    s2c_q   <= sq2z_q + RAD_W'(m2sq_q);
    dab_q   <= dx_q + dy_q;
    dc_q    <= dz_q;
    msum2_q <= {1'b0, m1sq_q} + {1'b0, m2sq_q};

    psq1_q  <= s1ab_q + s1c_q;
    psq2_q  <= s2ab_q + s2c_q;
    dot3_q  <= dab_q + dc_q;
    msum3_q <= msum2_q;

    prod4_q <= e1 * e2;
    esum4_q <= esum_full[OUT_W-1:0];
    dot4_q  <= dot_side;
    msum4_q <= msum_side;

    pos5_q  <= RAD_W'(msum4_q) + {prod4_q[RAD_W-2:0], 1'b0};
    dot5_q  <= dot4_q;
    esum5_q <= esum4_q;

    rad6_q  <= pos5_q - sub5;
    neg6_q  <= !dot5_q[RAD_W-1] && (pos5_q < sub5);
    esum6_q <= esum5_q;
  end

  tbim_sqrt #(.SIDE_W(RAD_W)) u_sqrt_e1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (psq1_q),
    .side_i  (dot3_q),
    .valid_o (ve1),
    .root_o  (e1),
    .side_o  (dot_side)
  );

  tbim_sqrt #(.SIDE_W(MSQ_W + 1)) u_sqrt_e2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (psq2_q),
    .side_i  (msum3_q),
    .valid_o (ve2),
    .root_o  (e2),
    .side_o  (msum_side)
  );

  // negative radicand: clamp to zero
  tbim_sqrt #(.SIDE_W(OUT_W + 1)) u_sqrt_mass (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v6_q),
    .rad_i   (neg6_q ? '0 : rad6_q),
    .side_i  ({neg6_q, esum6_q}),
    .valid_o (vm),
    .root_o  (mroot),
    .side_o  (mside)
  );

  assign done_o              = vm;
  assign pair_mass_o         = mroot[OUT_W-1:0];
  assign pair_energy_o       = mside[OUT_W-1:0];
  assign negative_radicand_o = mside[OUT_W];

`include "two_body_invariant_mass_unit_defines.svh"

  `TBIM_ASSERT_NOW(a_energy_lanes_aligned, 1'b1, ve1 == ve2)
  `TBIM_ASSERT_NOW(a_clamp_gives_zero, done_o && negative_radicand_o, pair_mass_o == '0)
  `TBIM_ASSERT_NEXT(a_accept_enters, accept, v1_q)
  `TBIM_ASSERT_NEXT(a_radicand_stage, v5_q, v6_q)

endmodule

[verif/two_body_invariant_mass_unit_tb.sv]
module two_body_invariant_mass_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbim_pkg::*;

  localparam int PBITS = 28;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [OUT_W-1:0] mass;
    logic [OUT_W-1:0] energy;
    logic             neg;
  } pair_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [PBITS-1:0] first_px_i = '0, first_py_i = '0, first_pz_i = '0;
  logic signed [PBITS-1:0] second_px_i = '0, second_py_i = '0, second_pz_i = '0;
  logic [2:0] first_hypothesis_i = '0, second_hypothesis_i = '0;
  logic done_o;
  logic [OUT_W-1:0] pair_mass_o, pair_energy_o;
  logic negative_radicand_o;

  pair_result_t pending_results[$];
  int fail_count = 0;
  bit steady_feed = 1'b0;

  two_body_invariant_mass_unit #(.MOMENTUM_BITS(PBITS)) DUT (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned hyp_mass(input logic [2:0] code);
    case (code)
      HYP_KAON, HYP_KAON_ALT: return 64'd497672;
      HYP_LAMBDA:             return 64'd1115683;
      HYP_ELECTRON:           return 64'd511;
      HYP_PION:               return 64'd139570;
      HYP_PROTON:             return 64'd938272;
      default:                return 64'd0;
    endcase
  endfunction

  function automatic pair_result_t predict_pair();
    pair_result_t res;
    longint ax, ay, az, bx, by, bz, dot;
    longint unsigned m1, m2, e1, e2, pos, rad;
    ax = longint'(first_px_i);  ay = longint'(first_py_i);  az = longint'(first_pz_i);
    bx = longint'(second_px_i); by = longint'(second_py_i); bz = longint'(second_pz_i);
    m1 = hyp_mass(first_hypothesis_i);
    m2 = hyp_mass(second_hypothesis_i);
    e1 = floor_root(ax * ax + ay * ay + az * az + m1 * m1);
    e2 = floor_root(bx * bx + by * by + bz * bz + m2 * m2);
    dot = ax * bx + ay * by + az * bz;
    pos = m1 * m1 + m2 * m2 + 2 * e1 * e2;
    res.neg = 1'b0;
    rad = 0;
    if (dot < 0) rad = pos + 2 * longint'(-dot);
    else if (pos >= 2 * longint'(dot)) rad = pos - 2 * longint'(dot);
    else res.neg = 1'b1;
    res.mass = OUT_W'(floor_root(rad));
    res.energy = OUT_W'(e1 + e2);
    return res;
  endfunction

  always @(posedge clk_i) begin
    pair_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word mass=%0d energy=%0d neg=%0b", $time,
                 pair_mass_o, pair_energy_o, negative_radicand_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (pair_mass_o !== exp_r.mass) begin
          $display("%0t: pair_mass expected %0d actual %0d", $time, exp_r.mass, pair_mass_o);
          fail_count++;
        end
        if (pair_energy_o !== exp_r.energy) begin
          $display("%0t: pair_energy expected %0d actual %0d", $time, exp_r.energy,
                   pair_energy_o);
          fail_count++;
        end
        if (negative_radicand_o !== exp_r.neg) begin
          $display("%0t: negative_radicand expected %0b actual %0b", $time, exp_r.neg,
                   negative_radicand_o);
          fail_count++;
        end
      end
    end
    if (rst_ni && start_i && !busy_o) pending_results.push_back(predict_pair());
  end

  task automatic send_pair(input logic signed [PBITS-1:0] ax, ay, az, bx, by, bz,
                           input logic [2:0] ha, hb);
    while (!steady_feed && $urandom_range(0, 99) < 37) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    first_px_i <= ax;  first_py_i <= ay;  first_pz_i <= az;
    second_px_i <= bx; second_py_i <= by; second_pz_i <= bz;
    first_hypothesis_i <= ha;
    second_hypothesis_i <= hb;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic logic signed [PBITS-1:0] rand_comp(input int scale);
    logic signed [PBITS-1:0] v;
    v = PBITS'($urandom);
    case (scale)
      0: v = v >>> (PBITS - 4);
      1: v = v >>> (PBITS - 12);
      2: v = v >>> (PBITS - 20);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_extremes();
    logic signed [PBITS-1:0] pmax, pmin;
    pmax = {1'b0, {(PBITS-1){1'b1}}};
    pmin = {1'b1, {(PBITS-1){1'b0}}};
    send_pair('0, '0, '0, '0, '0, '0, 3'd0, 3'd0);
    send_pair(pmax, pmax, pmax, pmax, pmax, pmax, HYP_LAMBDA, HYP_LAMBDA);
    send_pair(pmin, pmin, pmin, pmin, pmin, pmin, HYP_PROTON, HYP_PROTON);
    send_pair(pmax, pmax, pmax, pmin, pmin, pmin, HYP_LAMBDA, HYP_PROTON);
    send_pair(pmin, pmax, pmin, pmax, pmin, pmax, 3'd7, 3'd7);
    send_pair(PBITS'(-1), PBITS'(-1), PBITS'(-1), PBITS'(1), PBITS'(1), PBITS'(1),
              HYP_ELECTRON, HYP_PION);
  endtask

  task automatic test_hypotheses();
    for (int h = 0; h < 8; h++)
      send_pair(PBITS'(1000), PBITS'(-2000), PBITS'(3000), PBITS'(-400), PBITS'(500),
                PBITS'(600), 3'(h), 3'(7 - h));
  endtask

  task automatic test_negative_radicand();
    // rounded-down energies of parallel massless daughters undercut the dot term
    send_pair(PBITS'(1), PBITS'(1), PBITS'(0), PBITS'(1), PBITS'(1), PBITS'(0),
              3'd0, 3'd0);
    send_pair(PBITS'(5), PBITS'(7), PBITS'(3), PBITS'(5), PBITS'(7), PBITS'(3),
              3'd7, 3'd0);
    send_pair(PBITS'(123456), PBITS'(654321), PBITS'(111), PBITS'(123456),
              PBITS'(654321), PBITS'(111), 3'd0, 3'd0);
    send_pair(PBITS'(-3), PBITS'(2), PBITS'(1), PBITS'(-6), PBITS'(4), PBITS'(2),
              3'd0, 3'd7);
  endtask

  task automatic test_random(input int count);
    logic signed [PBITS-1:0] a[3], b[3];
    int sa, sb;
    for (int i = 0; i < count; i++) begin
      sa = $urandom_range(0, 3);
      sb = $urandom_range(0, 3);
      for (int k = 0; k < 3; k++) begin
        a[k] = rand_comp(sa);
        b[k] = rand_comp(sb);
      end
      if ($urandom_range(0, 4) == 0)
        for (int k = 0; k < 3; k++) b[k] = a[k] + rand_comp(0);
      send_pair(a[0], a[1], a[2], b[0], b[1], b[2], 3'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_hypotheses();
    test_negative_radicand();
    test_random(1300);
    steady_feed = 1'b1;
    test_random(600);
    steady_feed = 1'b0;
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("two_body_invariant_mass_unit regression: pass");
    else
      $display("two_body_invariant_mass_unit regression: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("two_body_invariant_mass_unit regression: fail");
    $finish;
  end

endmodule

[two_body_invariant_mass_unit.f]
+incdir+rtl
rtl/tbim_pkg.sv
rtl/tbim_sqrt.sv
rtl/two_body_invariant_mass_unit.sv
verif/two_body_invariant_mass_unit_tb.sv
